/* sv/bmhq_pkg.sv */
// Shared types and codes for the binary min-heap priority queue.
// No dependencies; imported by bmhq_store and binary_min_heap_queue.
`timescale 1ns / 1ps

package bmhq_pkg;

  // One heap entry: key orders the heap, payload rides along
  typedef struct packed {
    logic [31:0] key;
    logic [31:0] payload;
  } entry_t;

  // Request function codes
  localparam logic FUNC_INSERT  = 1'b0;
  localparam logic FUNC_EXTRACT = 1'b1;

  // Result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_UP_CMP,
    ST_PLACE,
    ST_EX_LOAD,
    ST_DN_CMP,
    ST_DONE
  } state_t;

endpackage

/* sv/bmhq_store.sv */
// Heap entry storage: one write port, two read ports with registered data.
// Depends on bmhq_pkg for entry_t.
`timescale 1ns / 1ps

module bmhq_store #(
  parameter int DEPTH = 64,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_addr,
  input  bmhq_pkg::entry_t     wr_data,
  input  logic [IDX_W-1:0]     rd_addr_a,
  input  logic [IDX_W-1:0]     rd_addr_b,
  output bmhq_pkg::entry_t     rd_data_a,
  output bmhq_pkg::entry_t     rd_data_b
);
  import bmhq_pkg::*;

  entry_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // two registered read ports
  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

/* sv/binary_min_heap_queue.sv */
// A finished result waits in ST_DONE while out_valid is still held by an unaccepted one;
// a full insert or an empty extract goes from ST_START straight to ST_DONE.
// One heap level is compared and moved per cycle through the two-port entry store.
// One request at a time: in_ready is high only in idle, so a new request waits until
// the level-at-a-time sift and the result hand-off are through.
// Reset (rst_n low, synchronous): entry count cleared, no result pending; store kept.
`timescale 1ns / 1ps

module binary_min_heap_queue #(
  parameter int CAPACITY = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_func,
  input  logic [31:0]                      in_key,
  input  logic [31:0]                      in_payload,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       out_status,
  output logic [31:0]                      out_key,
  output logic [31:0]                      out_payload,
  output logic [$clog2(CAPACITY+1)-1:0]    out_fill_count
);
  import bmhq_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CHD_W = IDX_W + 2;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [IDX_W-1:0]   pos_r, pos_nxt;
  entry_t             hold_r, hold_nxt;
  logic               func_r, func_nxt;
  logic [1:0]         res_status_r, res_status_nxt;
  entry_t             res_ent_r, res_ent_nxt;
  logic               out_valid_r;
  logic [1:0]         out_status_r;
  entry_t             out_ent_r;
  logic [CNT_W-1:0]   out_fill_r;

  // store interface
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_data;
  logic [IDX_W-1:0]   rd_addr_a, rd_addr_b;
  entry_t             rd_data_a, rd_data_b;

  // index arithmetic
  logic [IDX_W-1:0]   parent_idx, grand_idx, last_idx;
  logic [CHD_W-1:0]   left_idx, right_idx, mv_left, mv_right;
  logic               accept, out_load;
  logic               full, empty;
  logic               up_swap;
  logic               left_ok, right_ok, take_l, take_r, dn_move;
  logic [31:0]        best_key;
  entry_t             mv_ent;
  logic [IDX_W-1:0]   mv_idx;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  assign full  = (count_r == CNT_W'(CAPACITY));
  assign empty = (count_r == '0);

  assign parent_idx = (pos_r - IDX_W'(1)) >> 1;
  assign grand_idx  = (parent_idx - IDX_W'(1)) >> 1;
  assign last_idx   = IDX_W'(count_r - CNT_W'(1));
  assign left_idx   = (CHD_W'(pos_r) << 1) + CHD_W'(1);
  assign right_idx  = (CHD_W'(pos_r) << 1) + CHD_W'(2);

  // sift-up compare: moving entry against its parent
  assign up_swap = (hold_r.key < rd_data_a.key);

  // sift-down compare: left child first, right wins only if strictly smaller
  assign left_ok  = (left_idx < CHD_W'(count_r));
  assign right_ok = (right_idx < CHD_W'(count_r));
  assign take_l   = left_ok && (rd_data_a.key < hold_r.key);
  assign best_key = take_l ? rd_data_a.key : hold_r.key;
  assign take_r   = right_ok && (rd_data_b.key < best_key);
  assign dn_move  = take_l || take_r;
  assign mv_ent   = take_r ? rd_data_b : rd_data_a;
  assign mv_idx   = take_r ? right_idx[IDX_W-1:0] : left_idx[IDX_W-1:0];
  assign mv_left  = (CHD_W'(mv_idx) << 1) + CHD_W'(1);
  assign mv_right = (CHD_W'(mv_idx) << 1) + CHD_W'(2);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_START;
      end
      ST_START: begin
        if (func_r == FUNC_INSERT) begin
          if (full) begin
            state_nxt = ST_DONE;
          end else if (pos_r == '0) begin
            state_nxt = ST_PLACE;
          end else begin
            state_nxt = ST_UP_CMP;
          end
        end else begin
          state_nxt = empty ? ST_DONE : ST_EX_LOAD;
        end
      end
      ST_UP_CMP: begin
        if (!up_swap) begin
          state_nxt = ST_DONE;
        end else if (parent_idx == '0) begin
          state_nxt = ST_PLACE;
        end
      end
      ST_PLACE:   state_nxt = ST_DONE;
      ST_EX_LOAD: state_nxt = (count_r == '0) ? ST_DONE : ST_DN_CMP;
      ST_DN_CMP: begin
        if (!dn_move) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath next values and store controls
  always_comb begin
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    hold_nxt       = hold_r;
    func_nxt       = func_r;
    res_status_nxt = res_status_r;
    res_ent_nxt    = res_ent_r;
    wr_en          = 1'b0;
    wr_addr        = pos_r;
    wr_data        = hold_r;
    rd_addr_a      = parent_idx;
    rd_addr_b      = last_idx;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          func_nxt         = in_func;
          hold_nxt.key     = in_key;
          hold_nxt.payload = in_payload;
          pos_nxt          = (in_func == FUNC_INSERT) ? count_r[IDX_W-1:0] : '0;
        end
      end
      ST_START: begin
        res_status_nxt = STAT_OK;
        res_ent_nxt    = '0;
        if (func_r == FUNC_INSERT) begin
          if (full) begin
            res_status_nxt = STAT_FULL;
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
        end else if (empty) begin
          res_status_nxt = STAT_EMPTY;
        end else begin
          // fetch root and last entry together
          count_nxt = count_r - CNT_W'(1);
          rd_addr_a = '0;
          rd_addr_b = last_idx;
        end
      end
      ST_UP_CMP: begin
        wr_en = 1'b1;
        if (up_swap) begin
          // parent drops into the hole, hole moves up
          wr_data   = rd_data_a;
          pos_nxt   = parent_idx;
          rd_addr_a = grand_idx;
        end
      end
      ST_PLACE: begin
        wr_en = 1'b1;
      end
      ST_EX_LOAD: begin
        res_ent_nxt = rd_data_a;
        hold_nxt    = rd_data_b;
        rd_addr_a   = left_idx[IDX_W-1:0];
        rd_addr_b   = right_idx[IDX_W-1:0];
      end
      ST_DN_CMP: begin
        wr_en = 1'b1;
        if (dn_move) begin
          // smaller child rises into the hole, hole moves down
          wr_data   = mv_ent;
          pos_nxt   = mv_idx;
          rd_addr_a = mv_left[IDX_W-1:0];
          rd_addr_b = mv_right[IDX_W-1:0];
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    hold_r       <= hold_nxt;
    func_r       <= func_nxt;
    res_status_r <= res_status_nxt;
    res_ent_r    <= res_ent_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_ent_r    <= res_ent_r;
      out_fill_r   <= count_r;
    end
  end

  bmhq_store #(
    .DEPTH (CAPACITY),
    .IDX_W (IDX_W)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_key        = out_ent_r.key;
  assign out_payload    = out_ent_r.payload;
  assign out_fill_count = out_fill_r;

endmodule
